// ===== sv/mesp_pkg.sv =====
// ----------------------------------------------------------------------------
// MIDI event stream parser package
// Shared types and status codes for the track event parser.
// ----------------------------------------------------------------------------
package mesp_pkg;

   // Parse phase of the current event.
   typedef enum logic [2:0] {
      PH_DELTA   = 3'd0,
      PH_STATUS  = 3'd1,
      PH_DATA    = 3'd2,
      PH_MTYPE   = 3'd3,
      PH_LEN     = 3'd4,
      PH_PAYLOAD = 3'd5
   } phase_type;

   // Role tag reported with each byte.
   typedef enum logic [2:0] {
      RO_DELTA   = 3'd0,
      RO_STATUS  = 3'd1,
      RO_DATA    = 3'd2,
      RO_MTYPE   = 3'd3,
      RO_LEN     = 3'd4,
      RO_PAYLOAD = 3'd5,
      RO_ERROR   = 3'd6
   } role_type;

   // Status bytes and nibbles with special meaning.
   localparam logic [7:0] ST_SYSEX      = 8'hf0;
   localparam logic [7:0] ST_SYSEX_ESC  = 8'hf7;
   localparam logic [7:0] ST_META       = 8'hff;
   localparam logic [7:0] ST_TIME_CODE  = 8'hf1;
   localparam logic [7:0] ST_SONG_SEL   = 8'hf3;
   localparam logic [7:0] META_EOT      = 8'h2f;
   localparam logic [3:0] HI_NOTE_OFF   = 4'h8;
   localparam logic [3:0] HI_NOTE_ON    = 4'h9;
   localparam logic [3:0] HI_POLY_PRESS = 4'ha;
   localparam logic [3:0] HI_CTRL       = 4'hb;
   localparam logic [3:0] HI_PROGRAM    = 4'hc;
   localparam logic [3:0] HI_CHAN_PRESS = 4'hd;
   localparam logic [3:0] HI_PITCH      = 4'he;
   localparam logic [7:0] ST_RT_TICK    = 8'hf6;
   localparam logic [7:0] ST_RT_CLOCK   = 8'hf8;
   localparam logic [7:0] ST_RT_START   = 8'hfa;
   localparam logic [7:0] ST_RT_CONT    = 8'hfb;
   localparam logic [7:0] ST_RT_STOP    = 8'hfc;
   localparam logic [7:0] ST_RT_SENSE   = 8'hfe;

   // Parser state carried from byte to byte.
   typedef struct packed {
      phase_type   phase;
      logic [31:0] acc;
      logic [31:0] bytes_left;
      logic [7:0]  cur_status;
      logic [7:0]  meta_type;
      logic        chan_known;
      logic [3:0]  chan;
      logic        halted;
   } state_type;

   // One result item.
   typedef struct packed {
      role_type    role;
      logic [31:0] value;
      logic        value_done;
      logic [7:0]  event_status;
      logic        event_done;
      logic        end_of_track;
   } result_type;

   localparam state_type STATE_CLEAR = '{
      phase:      PH_DELTA,
      acc:        32'd0,
      bytes_left: 32'd0,
      cur_status: 8'd0,
      meta_type:  8'd0,
      chan_known: 1'b0,
      chan:       4'd0,
      halted:     1'b0
   };

endpackage

// ===== sv/mesp_if.sv =====
// ----------------------------------------------------------------------------
// MIDI event stream parser channels
// Valid/ready channels for the byte input and the tagged result output.
// ----------------------------------------------------------------------------

// Input byte channel.
interface mesp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;
   logic       track_start;

   modport source (output valid, output byte_in, output track_start, input ready);
   modport sink (input valid, input byte_in, input track_start, output ready);
   modport monitor (input valid, input ready, input byte_in, input track_start);
endinterface

// Tagged result channel.
interface mesp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  role;
   logic [31:0] value;
   logic        value_done;
   logic [7:0]  event_status;
   logic        event_done;
   logic        end_of_track;

   modport source (output valid, output role, output value, output value_done,
                   output event_status, output event_done, output end_of_track,
                   input ready);
   modport sink (input valid, input role, input value, input value_done,
                 input event_status, input event_done, input end_of_track,
                 output ready);
   modport monitor (input valid, input ready, input role, input value,
                    input value_done, input event_status, input event_done,
                    input end_of_track);
endinterface

// ===== sv/mesp_step.sv =====
// ----------------------------------------------------------------------------
// MIDI event stream parser step
// Combinational next state and result for one byte of a track body.
// ----------------------------------------------------------------------------
module mesp_step (
   input  logic [7:0]             byte_in,
   input  logic                   track_start,
   input  mesp_pkg::state_type    cur_state,
   output mesp_pkg::state_type    next_state,
   output mesp_pkg::result_type   result
);
   import mesp_pkg::*;

   // Classes of a byte seen in the status position.
   typedef enum logic [2:0] {
      CL_LENGTH,
      CL_META,
      CL_ONE,
      CL_TWO,
      CL_REALTIME,
      CL_RUNNING
   } class_type;

   state_type   s;
   class_type   cls;
   logic [3:0]  hi;
   logic [31:0] acc_shift;
   logic        vl_last;
   logic        bl_last;
   logic        status_err;
   logic        err;
   logic        eot_match;
   logic [7:0]  status_eff;

   // A track start clears everything before the byte is handled.
   assign s = track_start ? STATE_CLEAR : cur_state;

   assign hi        = byte_in[7:4];
   assign acc_shift = {s.acc[24:0], byte_in[6:0]};
   assign vl_last   = ~byte_in[7];
   assign bl_last   = (s.bytes_left[31:1] == 31'd0);
   assign eot_match = (s.cur_status == ST_META) && (s.meta_type == META_EOT);

   // Classify the byte as a status.
   always_comb begin
      priority if (byte_in == ST_SYSEX || byte_in == ST_SYSEX_ESC) begin
         cls = CL_LENGTH;
      end else if (byte_in == ST_META) begin
         cls = CL_META;
      end else if (byte_in == ST_TIME_CODE || byte_in == ST_SONG_SEL) begin
         cls = CL_ONE;
      end else if (byte_in == ST_RT_TICK || byte_in == ST_RT_CLOCK ||
                   byte_in == ST_RT_START || byte_in == ST_RT_CONT ||
                   byte_in == ST_RT_STOP || byte_in == ST_RT_SENSE) begin
         cls = CL_REALTIME;
      end else if (hi == HI_PROGRAM || hi == HI_CHAN_PRESS) begin
         cls = CL_ONE;
      end else if (hi == HI_NOTE_OFF || hi == HI_NOTE_ON || hi == HI_POLY_PRESS ||
                   hi == HI_CTRL || hi == HI_PITCH) begin
         cls = CL_TWO;
      end else begin
         cls = CL_RUNNING;
      end
   end

   // Running status needs a kept note-on channel.
   assign status_err = (s.phase == PH_STATUS) && (cls == CL_RUNNING) && !s.chan_known;
   assign err        = s.halted || status_err;
   assign status_eff = (cls == CL_RUNNING) ? {HI_NOTE_ON, s.chan} : byte_in;

   // Next state.
   always_comb begin
      next_state = s;
      if (err) begin
         next_state.halted = 1'b1;
      end else begin
         unique case (s.phase)
            PH_STATUS: begin
               next_state.cur_status = status_eff;
               unique case (cls)
                  CL_LENGTH: begin
                     next_state.phase = PH_LEN;
                     next_state.acc   = 32'd0;
                  end
                  CL_META: begin
                     next_state.phase = PH_MTYPE;
                  end
                  CL_REALTIME: begin
                     next_state.phase      = PH_DELTA;
                     next_state.bytes_left = 32'd0;
                  end
                  CL_TWO: begin
                     next_state.phase      = PH_DATA;
                     next_state.bytes_left = 32'd2;
                     if (hi == HI_NOTE_ON && !s.chan_known) begin
                        next_state.chan_known = 1'b1;
                        next_state.chan       = byte_in[3:0];
                     end
                  end
                  default: begin
                     // One data byte left: a single-byte message or running status.
                     next_state.phase      = PH_DATA;
                     next_state.bytes_left = 32'd1;
                  end
               endcase
            end
            PH_DATA, PH_PAYLOAD: begin
               if (bl_last) begin
                  next_state.phase      = PH_DELTA;
                  next_state.bytes_left = 32'd0;
                  if (eot_match) begin
                     next_state.chan_known = 1'b0;
                  end
               end else begin
                  next_state.bytes_left = s.bytes_left - 32'd1;
               end
            end
            PH_MTYPE: begin
               next_state.meta_type = byte_in;
               next_state.acc       = 32'd0;
               next_state.phase     = PH_LEN;
            end
            PH_LEN: begin
               next_state.acc = acc_shift;
               if (vl_last) begin
                  next_state.acc = 32'd0;
                  if (acc_shift == 32'd0) begin
                     next_state.phase      = PH_DELTA;
                     next_state.bytes_left = 32'd0;
                     if (eot_match) begin
                        next_state.chan_known = 1'b0;
                     end
                  end else begin
                     next_state.phase      = PH_PAYLOAD;
                     next_state.bytes_left = acc_shift;
                  end
               end
            end
            default: begin
               // Delta time; unused phase codes count as delta too.
               next_state.phase = PH_DELTA;
               next_state.acc   = acc_shift;
               if (vl_last) begin
                  next_state.acc   = 32'd0;
                  next_state.phase = PH_STATUS;
               end
            end
         endcase
      end
   end

   // Result fields.
   always_comb begin
      result = '{role: RO_ERROR, value: 32'd0, value_done: 1'b0,
                 event_status: 8'd0, event_done: 1'b0, end_of_track: 1'b0};
      if (!err) begin
         unique case (s.phase)
            PH_STATUS: begin
               result.role         = (cls == CL_RUNNING) ? RO_DATA : RO_STATUS;
               result.event_status = status_eff;
               result.event_done   = (cls == CL_REALTIME);
            end
            PH_DATA, PH_PAYLOAD: begin
               result.role         = (s.phase == PH_DATA) ? RO_DATA : RO_PAYLOAD;
               result.event_status = s.cur_status;
               result.event_done   = bl_last;
               result.end_of_track = bl_last && eot_match;
            end
            PH_MTYPE: begin
               result.role         = RO_MTYPE;
               result.event_status = s.cur_status;
            end
            PH_LEN: begin
               result.role         = RO_LEN;
               result.event_status = s.cur_status;
               if (vl_last) begin
                  result.value_done   = 1'b1;
                  result.value        = acc_shift;
                  result.event_done   = (acc_shift == 32'd0);
                  result.end_of_track = (acc_shift == 32'd0) && eot_match;
               end
            end
            default: begin
               result.role = RO_DELTA;
               if (vl_last) begin
                  result.value_done = 1'b1;
                  result.value      = acc_shift;
               end
            end
         endcase
      end
   end

endmodule

// ===== sv/midi_event_stream_parser_top.sv =====
// Each result is registered and appears in the cycle after its byte is taken.
// Throughput: one byte per cycle while the output takes each result.
// A result that waits on the output holds off the next byte until it is taken.
// Reset (synchronous, active high) returns the parser to the delta phase with
// no kept channel and no error, and empties the result register.
// ----------------------------------------------------------------------------
// MIDI event stream parser
// Tags each byte of a MIDI track body with its role, running status applied.
// ----------------------------------------------------------------------------
module midi_event_stream_parser_top (
   input logic        clock,
   input logic        reset,
   mesp_req_if.sink   req_bus,
   mesp_rsp_if.source rsp_bus
);
   import mesp_pkg::*;

   state_type  state_ff;
   state_type  state_in;
   result_type result_in;
   result_type rsp_data_ff;
   logic       rsp_valid_ff;
   logic       req_take;

   // A byte moves in whenever the result register is free or being emptied.
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_take      = req_bus.valid && req_bus.ready;

   mesp_step u_step (
      .byte_in     (req_bus.byte_in),
      .track_start (req_bus.track_start),
      .cur_state   (state_ff),
      .next_state  (state_in),
      .result      (result_in)
   );

   // Parser state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_CLEAR;
      end else if (req_take) begin
         state_ff <= state_in;
      end
   end

   // Result register valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_data_ff <= result_in;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.role         = rsp_data_ff.role;
   assign rsp_bus.value        = rsp_data_ff.value;
   assign rsp_bus.value_done   = rsp_data_ff.value_done;
   assign rsp_bus.event_status = rsp_data_ff.event_status;
   assign rsp_bus.event_done   = rsp_data_ff.event_done;
   assign rsp_bus.end_of_track = rsp_data_ff.end_of_track;

endmodule

// ===== sv/mesp_checker.sv =====
// ----------------------------------------------------------------------------
// MIDI event stream parser checker
// Port-level properties of the parser, attached to the top level.
// ----------------------------------------------------------------------------
module mesp_checker (
   input logic        clock,
   input logic        reset,
   mesp_req_if.sink   req_bus,
   mesp_rsp_if.source rsp_bus
);
   import mesp_pkg::*;

   logic req_take;
   logic rsp_take;

   assign req_take = req_bus.valid && req_bus.ready;
   assign rsp_take = rsp_bus.valid && rsp_bus.ready;

   // Every taken byte shows its result in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_take |=> rsp_bus.valid)
      else $error("result missing after byte transfer");

   // A result that is taken with no new byte leaves the output empty.
   assert property (@(posedge clock) disable iff (reset)
      rsp_take && !req_take |=> !rsp_bus.valid)
      else $error("result repeated after transfer");

   // A stalled result holds its role, value, event status and event-done flag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.ready |=>
         rsp_bus.valid && $stable(rsp_bus.role) && $stable(rsp_bus.value) &&
         $stable(rsp_bus.event_status) && $stable(rsp_bus.event_done))
      else $error("stalled result changed");

   // The first byte of a track is never an error.
   assert property (@(posedge clock) disable iff (reset)
      req_take && req_bus.track_start |=> rsp_bus.role != RO_ERROR)
      else $error("error reported on track start byte");

   // End of track only closes a meta event.
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.end_of_track |->
         rsp_bus.event_done && rsp_bus.event_status == ST_META &&
         (rsp_bus.role == RO_LEN || rsp_bus.role == RO_PAYLOAD))
      else $error("end of track outside a meta event");

endmodule

bind midi_event_stream_parser_top mesp_checker u_mesp_checker (
   .clock   (clock),
   .reset   (reset),
   .req_bus (req_bus),
   .rsp_bus (rsp_bus)
);

// ===== test/midi_check_pkg.sv =====
// ----------------------------------------------------------------------------
// MIDI event stream parser checker
// Predicts the role tag of every byte and compares it with the tagged results.
// ----------------------------------------------------------------------------
package midi_check_pkg;

   import mesp_pkg::*;

   class midi_tag_scoreboard;

      // Predicted parser state.
      phase_type   ph;
      logic [31:0] num_acc;
      logic [31:0] left;
      logic [7:0]  ev_status;
      logic [7:0]  meta_kind;
      logic        chan_known;
      logic [3:0]  chan;
      logic        stopped;

      result_type  expected_tags[$];
      int          mismatch_count;

      function new();
         clear_track();
         mismatch_count = 0;
      endfunction

      function void clear_track();
         ph         = PH_DELTA;
         num_acc    = '0;
         left       = '0;
         ev_status  = '0;
         meta_kind  = '0;
         chan_known = 1'b0;
         chan       = '0;
         stopped    = 1'b0;
      endfunction

      function int pending();
         return expected_tags.size();
      endfunction

      // Closes the current event and tells whether it was the end of the track.
      function logic close_event();
         logic eot;
         eot = (ev_status == ST_META) && (meta_kind == META_EOT);
         if (eot) begin
            chan_known = 1'b0;
         end
         ph   = PH_DELTA;
         left = '0;
         return eot;
      endfunction

      // Works out the tag of one accepted byte and queues it.
      function void note_byte(logic [7:0] b, logic ts);
         result_type r;
         logic       fault;
         logic [3:0] hi;
         r      = '0;
         r.role = RO_ERROR;
         fault  = 1'b0;
         hi     = b[7:4];
         if (ts) begin
            clear_track();
         end
         if (stopped) begin
            fault = 1'b1;
         end else begin
            case (ph)
               PH_STATUS: begin
                  r.role    = RO_STATUS;
                  ev_status = b;
                  if (b == ST_SYSEX || b == ST_SYSEX_ESC) begin
                     ph      = PH_LEN;
                     num_acc = '0;
                  end else if (b == ST_META) begin
                     ph = PH_MTYPE;
                  end else if (b == ST_TIME_CODE || b == ST_SONG_SEL) begin
                     ph   = PH_DATA;
                     left = 1;
                  end else if (b inside {ST_RT_TICK, ST_RT_CLOCK, ST_RT_START, ST_RT_CONT,
                                         ST_RT_STOP, ST_RT_SENSE}) begin
                     r.event_done   = 1'b1;
                     r.end_of_track = close_event();
                  end else begin
                     // The first note-on of a track, or after an end of track, fixes the running-status channel.
                     if (hi == HI_NOTE_ON && !chan_known) begin
                        chan_known = 1'b1;
                        chan       = b[3:0];
                     end
                     if (hi == HI_PROGRAM || hi == HI_CHAN_PRESS) begin
                        ph   = PH_DATA;
                        left = 1;
                     end else if (hi inside {HI_NOTE_OFF, HI_NOTE_ON, HI_POLY_PRESS, HI_CTRL,
                                             HI_PITCH}) begin
                        ph   = PH_DATA;
                        left = 2;
                     end else if (chan_known) begin
                        // Not a usable status: first data byte of a note-on.
                        r.role    = RO_DATA;
                        ev_status = {HI_NOTE_ON, chan};
                        ph        = PH_DATA;
                        left      = 1;
                     end else begin
                        fault = 1'b1;
                     end
                  end
                  r.event_status = ev_status;
               end
               PH_DATA, PH_PAYLOAD: begin
                  r.role         = (ph == PH_DATA) ? RO_DATA : RO_PAYLOAD;
                  r.event_status = ev_status;
                  if (left != 0) begin
                     left--;
                  end
                  if (left == 0) begin
                     r.event_done   = 1'b1;
                     r.end_of_track = close_event();
                  end
               end
               PH_MTYPE: begin
                  r.role         = RO_MTYPE;
                  r.event_status = ev_status;
                  meta_kind      = b;
                  num_acc        = '0;
                  ph             = PH_LEN;
               end
               PH_LEN: begin
                  r.role         = RO_LEN;
                  r.event_status = ev_status;
                  num_acc        = {num_acc[24:0], b[6:0]};
                  if (!b[7]) begin
                     r.value_done = 1'b1;
                     r.value      = num_acc;
                     left         = num_acc;
                     num_acc      = '0;
                     if (left == 0) begin
                        r.event_done   = 1'b1;
                        r.end_of_track = close_event();
                     end else begin
                        ph = PH_PAYLOAD;
                     end
                  end
               end
               default: begin
                  // Delta time; unused phase codes land here too.
                  r.role  = RO_DELTA;
                  ph      = PH_DELTA;
                  num_acc = {num_acc[24:0], b[6:0]};
                  if (!b[7]) begin
                     r.value_done = 1'b1;
                     r.value      = num_acc;
                     num_acc      = '0;
                     ph           = PH_STATUS;
                  end
               end
            endcase
         end
         // An error tag carries nothing else and halts the track.
         if (fault) begin
            stopped = 1'b1;
            r       = '0;
            r.role  = RO_ERROR;
         end
         expected_tags.push_back(r);
      endfunction

      // Counts every mismatch but prints only the first hundred.
      task report(string msg);
         if (mismatch_count < 100) begin
            $display("MISMATCH: %s", msg);
         end
         mismatch_count++;
      endtask

      task compare_field(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want) begin
            report($sformatf("%s is %0h, expected %0h", name, got, want));
         end
      endtask

      // Compares one result transfer with the oldest predicted tag.
      task check_result(result_type got);
         result_type want;
         if (expected_tags.size() == 0) begin
            report("result arrived with no byte waiting for it");
         end else begin
            want = expected_tags.pop_front();
            compare_field("role", 32'(got.role), 32'(want.role));
            compare_field("value", got.value, want.value);
            compare_field("value_done", 32'(got.value_done), 32'(want.value_done));
            compare_field("event_status", 32'(got.event_status), 32'(want.event_status));
            compare_field("event_done", 32'(got.event_done), 32'(want.event_done));
            compare_field("end_of_track", 32'(got.end_of_track), 32'(want.end_of_track));
         end
      endtask

   endclass

endpackage

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// MIDI event stream parser testbench
// Feeds directed and random track bodies byte by byte under random idling and
// back-pressure, and checks every tagged result against a predicted tag.
// ----------------------------------------------------------------------------
module tb_top;

   import mesp_pkg::*;
   import midi_check_pkg::*;

   localparam int RESET_CYCLES = 5;
   localparam int RANDOM_ITEMS = 1350;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 20;
   localparam int CYCLE_LIMIT  = 500000;

   // One byte of the stream together with its track start flag.
   typedef struct packed {
      logic       first;
      logic [7:0] value;
   } stream_byte_type;

   localparam logic [3:0] CHANNEL_KINDS [7] = '{HI_NOTE_OFF, HI_NOTE_ON, HI_POLY_PRESS,
                                                HI_CTRL, HI_PROGRAM, HI_CHAN_PRESS, HI_PITCH};
   localparam logic [7:0] REALTIME_CODES [6] = '{ST_RT_TICK, ST_RT_CLOCK, ST_RT_START,
                                                 ST_RT_CONT, ST_RT_STOP, ST_RT_SENSE};
   localparam logic [7:0] UNDEFINED_CODES [5] = '{8'hf2, 8'hf4, 8'hf5, 8'hf9, 8'hfd};

   // Opening track: note-on sets the channel, running status, real time,
   // zero-length sysex, end of track forgetting the channel, the error halt
   // and a delta that wraps past 32 bits after a new track start.
   localparam stream_byte_type OPENING [25] = '{
      {1'b1, 8'h00}, {1'b0, HI_NOTE_ON, 4'h0}, {1'b0, 8'h3c}, {1'b0, 8'h7f},
      {1'b0, 8'h81}, {1'b0, 8'h00}, {1'b0, 8'h40}, {1'b0, 8'h50},
      {1'b0, 8'h00}, {1'b0, ST_RT_CLOCK},
      {1'b0, 8'h00}, {1'b0, ST_SYSEX}, {1'b0, 8'h00},
      {1'b0, 8'h00}, {1'b0, ST_META}, {1'b0, META_EOT}, {1'b0, 8'h00},
      {1'b0, 8'h00}, {1'b0, 8'hf4}, {1'b0, 8'h12},
      {1'b1, 8'hff}, {1'b0, 8'hff}, {1'b0, 8'hff}, {1'b0, 8'hff}, {1'b0, 8'h7f}
   };

   logic clock;
   logic reset;

   mesp_req_if req_bus ();
   mesp_rsp_if rsp_bus ();

   midi_event_stream_parser_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   midi_tag_scoreboard sb;
   stream_byte_type    stream[$];
   int                 bytes_sent = 0;
   int                 cycle_count;
   bit                 hold_request = 1'b0;

   // Clock.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Idle length: mostly none or short, now and then long.
   function automatic int idle_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 30);
   endfunction

   function automatic void push_byte(logic [7:0] b, logic ts = 1'b0);
      stream.push_back('{first: ts, value: b});
   endfunction

   // Variable-length number, 7 bits per byte, most significant group first.
   function automatic void push_number(logic [31:0] v);
      int          groups;
      int          i;
      logic [31:0] part;
      groups = 1;
      while (groups < 5 && (v >> (7 * groups)) != 0) groups++;
      for (i = groups - 1; i >= 0; i--) begin
         part = v >> (7 * i);
         push_byte({i != 0, part[6:0]});
      end
   endfunction

   // Delta time, sometimes with extra leading groups that wrap the value.
   function automatic void push_delta();
      if ($urandom_range(0, 7) == 0) begin
         repeat ($urandom_range(1, 3)) push_byte(8'h80 | 8'($urandom));
      end
      push_number($urandom >> $urandom_range(0, 31));
   endfunction

   function automatic void push_payload(int len);
      push_number(len);
      repeat (len) push_byte(8'($urandom));
   endfunction

   // One event with its delta; returns 1 when the event is broken on purpose.
   function automatic bit push_event();
      int         kind;
      logic [3:0] hi;
      push_delta();
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
         hi = CHANNEL_KINDS[$urandom_range(0, 6)];
         push_byte({hi, 4'($urandom)});
         repeat ((hi == HI_PROGRAM || hi == HI_CHAN_PRESS) ? 1 : 2)
            push_byte(8'($urandom_range(0, 127)));
      end else if (kind < 50) begin
         // Running status: plain data or an undefined status byte.
         if ($urandom_range(0, 3) == 0) push_byte(UNDEFINED_CODES[$urandom_range(0, 4)]);
         else push_byte(8'($urandom_range(0, 127)));
         push_byte(8'($urandom_range(0, 127)));
      end else if (kind < 57) begin
         push_byte($urandom_range(0, 1) ? ST_TIME_CODE : ST_SONG_SEL);
         push_byte(8'($urandom_range(0, 127)));
      end else if (kind < 63) begin
         push_byte(REALTIME_CODES[$urandom_range(0, 5)]);
      end else if (kind < 75) begin
         push_byte($urandom_range(0, 1) ? ST_SYSEX : ST_SYSEX_ESC);
         push_payload($urandom_range(0, 6));
      end else if (kind < 93) begin
         push_byte(ST_META);
         push_byte(8'($urandom));
         push_payload($urandom_range(0, 6));
      end else begin
         // Broken: any byte as status, or a meta with a huge length.
         if ($urandom_range(0, 1)) begin
            push_byte(8'($urandom));
         end else begin
            push_byte(ST_META);
            push_byte(8'($urandom));
            push_number($urandom | 32'h100);
            repeat ($urandom_range(1, 4)) push_byte(8'($urandom));
         end
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // A track body with random content, at times broken on purpose or cut short.
   function automatic void build_track();
      int head;
      int cut;
      head = stream.size();
      if ($urandom_range(0, 4) != 0) begin
         push_delta();
         push_byte({HI_NOTE_ON, 4'($urandom)});
         push_byte(8'($urandom_range(0, 127)));
         push_byte(8'($urandom_range(0, 127)));
      end
      repeat ($urandom_range(2, 10)) begin
         if (push_event()) break;
      end
      if ($urandom_range(0, 9) < 7) begin
         push_delta();
         push_byte(ST_META);
         push_byte(META_EOT);
         push_byte(8'h00);
         // Events after the end of track run without a kept channel.
         if ($urandom_range(0, 2) == 0) void'(push_event());
      end
      if ($urandom_range(0, 5) == 0) begin
         cut = $urandom_range(head + 1, stream.size());
         while (stream.size() > cut) void'(stream.pop_back());
      end
      stream[head].first = 1'b1;
   endfunction

   function automatic void push_noise();
      repeat ($urandom_range(4, 16)) push_byte(8'($urandom), $urandom_range(0, 5) == 0);
   endfunction

   // Offers one byte and waits for its transfer.
   task automatic send_byte(stream_byte_type item, int gap);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.byte_in     <= item.value;
      req_bus.track_start <= item.first;
      do @(posedge clock); while (!req_bus.ready);
      bytes_sent++;
   endtask

   task automatic send_stream(bit calm);
      stream_byte_type item;
      while (stream.size() != 0) begin
         item = stream.pop_front();
         send_byte(item, calm ? 0 : idle_cycles());
      end
   endtask

   // Stimulus and end of run.
   initial begin : stimulus
      int scenario;
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.byte_in     <= '0;
      req_bus.track_start <= 1'b0;
      sb = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (OPENING[i]) stream.push_back(OPENING[i]);
      send_stream(1'b0);

      scenario = 0;
      while (bytes_sent < $size(OPENING) + RANDOM_ITEMS) begin
         if (scenario % 50 == 20) begin
            hold_request = 1'b1;
         end
         if (scenario % 50 == 10) begin
            // Pause until every expected result has come back.
            req_bus.valid <= 1'b0;
            do @(posedge clock); while (sb.pending() != 0);
         end
         if ($urandom_range(0, 99) < 85) build_track();
         else push_noise();
         send_stream($urandom_range(0, 3) == 0);
         scenario++;
      end
      req_bus.valid <= 1'b0;

      // Let the monitor note the last transfer before looking at the queue.
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Result side: random stalls, calm stretches and the long hold-off.
   initial begin : receiver
      int held;
      int stall;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_bus.ready <= 1'b0;
            held = 0;
            while (held < HOLD_CYCLES) begin
               @(posedge clock);
               held++;
            end
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(20, 80)) @(posedge clock);
         end else begin
            stall = idle_cycles();
            if (stall > 0) begin
               rsp_bus.ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end
      end
   end

   // Transfers on both channels, sampled at the clock edge.
   always @(posedge clock) begin : monitor
      result_type got;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            sb.note_byte(req_bus.byte_in, req_bus.track_start);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.role         = role_type'(rsp_bus.role);
            got.value        = rsp_bus.value;
            got.value_done   = rsp_bus.value_done;
            got.event_status = rsp_bus.event_status;
            got.event_done   = rsp_bus.event_done;
            got.end_of_track = rsp_bus.end_of_track;
            sb.check_result(got);
         end
      end
   end

   // Timeout.
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Verification failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/mesp_pkg.sv
sv/mesp_if.sv
sv/mesp_step.sv
sv/midi_event_stream_parser_top.sv
sv/mesp_checker.sv
test/midi_check_pkg.sv
test/tb_top.sv
